// ===== rtl/vpss_pkg.sv =====
// vpss_pkg: shared types, codes and helpers of the valve/pump step sequencer
// no dependencies; imported by every module of the block
`default_nettype none

package vpss_pkg;

	// field widths
	localparam int unsigned MODE_W    = 2;
	localparam int unsigned STAMP_W   = 32;
	localparam int unsigned PHASE_W   = 4;
	localparam int unsigned VALVE_W   = 6;
	localparam int unsigned PUMP_W    = 2;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 24;

	// scaling of seconds and extra drain time on abort during fill
	localparam logic [25:0] MS_PER_S       = 26'd1000;
	localparam logic [33:0] ABORT_EXTRA_MS = 34'd1000;

	// valve bits
	localparam logic [VALVE_W-1:0] WATER_BIT = 6'h10;
	localparam logic [VALVE_W-1:0] WASTE_BIT = 6'h20;

	// first chemical code that is handled as water
	localparam logic [2:0] CHEM_WATER = 3'd4;

	// reset values of the clean times
	localparam logic [15:0] CLEAN_MS_RST = 16'd5000;

	typedef enum logic [MODE_W-1:0] {
		MODE_TICK  = 2'd0,
		MODE_ABORT = 2'd1,
		MODE_BEGIN = 2'd2
	} mode_t;

	typedef enum logic [PHASE_W-1:0] {
		PH_STARTPRE  = 4'd0,
		PH_PRECLEAN  = 4'd1,
		PH_STARTLOAD = 4'd2,
		PH_LOAD      = 4'd3,
		PH_EXECUTE   = 4'd4,
		PH_UNLOAD    = 4'd5,
		PH_ABORT     = 4'd6,
		PH_STARTPOST = 4'd7,
		PH_POSTCLEAN = 4'd8,
		PH_FINISHED  = 4'd9
	} phase_t;

	typedef enum logic [PUMP_W-1:0] {
		PUMP_STOP = 2'd0,
		PUMP_IN   = 2'd1,
		PUMP_OUT  = 2'd2
	} pump_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STEP_SECONDS = 3'd0,
		CFG_FILL_MS      = 3'd1,
		CFG_CHEM_SELECT  = 3'd2,
		CFG_PRE_CLEAN_EN = 3'd3,
		CFG_PRE_CLEAN_MS = 3'd4,
		CFG_POST_CLEAN   = 3'd5
	} cfg_idx_t;

	// configuration register set
	typedef struct packed {
		logic [15:0] step_seconds;
		logic [23:0] fill_ms;
		logic [2:0]  chem_select;
		logic        pre_clean_enable;
		logic [15:0] pre_clean_ms;
		logic [15:0] post_clean_ms;
	} cfg_t;

	// one input word
	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [STAMP_W-1:0] now_ms;
	} item_t;

	// one result word
	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [VALVE_W-1:0] valve_mask;
		logic [PUMP_W-1:0]  pump_mode;
		logic [STAMP_W-1:0] elapsed_ms;
		logic               done_res;
	} res_t;

	// valve of the selected chemical; codes four and up use the water valve
	function automatic logic [VALVE_W-1:0] target_bit(input logic [2:0] chem);
		logic [VALVE_W-1:0] bits;
		bits = 6'h01 << chem;
		if (chem >= CHEM_WATER) begin
			bits = WATER_BIT;
		end
		return bits;
	endfunction

	// valve used to empty the tank; water goes to waste
	function automatic logic [VALVE_W-1:0] drain_bit(input logic [2:0] chem);
		logic [VALVE_W-1:0] bits;
		bits = target_bit(chem);
		if (chem >= CHEM_WATER) begin
			bits = WASTE_BIT;
		end
		return bits;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/vpss_core.sv =====
// vpss_core: sequencer state and its combinational update for one word
// depends on vpss_pkg
`default_nettype none

module vpss_core import vpss_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  step_en,
	input  wire item_t item,
	input  wire cfg_t  cfg,
	output res_t       res
);

	logic [PHASE_W-1:0] phase_q, phase_d;
	logic [STAMP_W-1:0] start_q, start_d;
	logic [STAMP_W-1:0] elapsed_q, elapsed_d;
	logic               started_q, started_d;
	logic [STAMP_W-1:0] step_ms_q, step_ms_d;
	logic [VALVE_W-1:0] valve_q, valve_d;
	logic [PUMP_W-1:0]  pump_q, pump_d;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_FINISHED;
			start_q   <= '0;
			elapsed_q <= '0;
			started_q <= 1'b0;
			step_ms_q <= '0;
			valve_q   <= '0;
			pump_q    <= PUMP_STOP;
		end else if (step_en) begin
			phase_q   <= phase_d;
			start_q   <= start_d;
			elapsed_q <= elapsed_d;
			started_q <= started_d;
			step_ms_q <= step_ms_d;
			valve_q   <= valve_d;
			pump_q    <= pump_d;
		end
	end

	// next state for one word
	always_comb begin
		logic [STAMP_W-1:0] stamp;
		logic [STAMP_W-1:0] e;
		logic [33:0]        exec_sum;
		logic [33:0]        drain_sum;
		logic [33:0]        abort_sum;
		logic [25:0]        begin_ms;
		logic               is_water;
		logic [VALVE_W-1:0] tgt;
		logic [VALVE_W-1:0] drn;

		phase_d   = phase_q;
		start_d   = start_q;
		elapsed_d = elapsed_q;
		started_d = started_q;
		step_ms_d = step_ms_q;
		valve_d   = valve_q;
		pump_d    = pump_q;

		is_water = (cfg.chem_select >= CHEM_WATER);
		tgt      = target_bit(cfg.chem_select);
		drn      = drain_bit(cfg.chem_select);

		// a zero stamp means the timer has not been armed yet
		stamp = (start_q == '0) ? item.now_ms : start_q;
		e     = item.now_ms - stamp;

		exec_sum  = {2'b0, e} + {10'b0, cfg.fill_ms} + {18'b0, cfg.post_clean_ms};
		drain_sum = {2'b0, e} + {18'b0, cfg.post_clean_ms};
		abort_sum = {2'b0, elapsed_q} + {18'b0, cfg.post_clean_ms} + ABORT_EXTRA_MS;
		begin_ms  = {10'b0, cfg.step_seconds} * MS_PER_S;

		case (item.mode)
			MODE_TICK: begin
				start_d   = stamp;
				elapsed_d = e;
				case (phase_q)
					PH_STARTPRE: begin
						valve_d = valve_q | WASTE_BIT;
						pump_d  = PUMP_OUT;
						phase_d = PH_PRECLEAN;
					end
					PH_PRECLEAN: begin
						if (e >= {16'b0, cfg.pre_clean_ms}) begin
							valve_d = valve_q & ~WASTE_BIT;
							pump_d  = PUMP_STOP;
							phase_d = PH_STARTLOAD;
						end
					end
					PH_STARTLOAD: begin
						valve_d   = valve_q | tgt;
						pump_d    = PUMP_IN;
						elapsed_d = '0;
						start_d   = item.now_ms;
						started_d = 1'b1;
						phase_d   = PH_LOAD;
					end
					PH_LOAD: begin
						if (e >= {8'b0, cfg.fill_ms}) begin
							valve_d = valve_q & ~tgt;
							pump_d  = PUMP_STOP;
							phase_d = PH_EXECUTE;
						end
					end
					PH_EXECUTE: begin
						if (exec_sum >= {2'b0, step_ms_q}) begin
							valve_d = valve_q | drn;
							pump_d  = PUMP_OUT;
							phase_d = PH_UNLOAD;
						end
					end
					PH_UNLOAD, PH_ABORT: begin
						if (drain_sum >= {2'b0, step_ms_q}) begin
							if (!is_water) begin
								valve_d = valve_q & ~tgt;
							end
							phase_d = PH_STARTPOST;
						end
					end
					PH_STARTPOST: begin
						valve_d = valve_q | WASTE_BIT;
						pump_d  = PUMP_OUT;
						phase_d = PH_POSTCLEAN;
					end
					PH_POSTCLEAN: begin
						if (e >= step_ms_q) begin
							valve_d = valve_q & ~WASTE_BIT;
							pump_d  = PUMP_STOP;
							phase_d = PH_FINISHED;
						end
					end
					default: begin
					end
				endcase
			end
			MODE_ABORT: begin
				// abort only acts before the drain has begun
				if (phase_q == PH_STARTPRE || phase_q == PH_PRECLEAN
						|| phase_q == PH_STARTLOAD || phase_q == PH_LOAD
						|| phase_q == PH_EXECUTE) begin
					if (phase_q == PH_LOAD) begin
						step_ms_d = (abort_sum[33:32] != 2'b00) ? '1 : abort_sum[31:0];
					end else if (phase_q == PH_EXECUTE) begin
						step_ms_d = {8'b0, cfg.fill_ms} + {16'b0, cfg.post_clean_ms};
					end else begin
						step_ms_d = '0;
					end
					elapsed_d = '0;
					start_d   = item.now_ms;
					valve_d   = valve_q | drn;
					pump_d    = PUMP_OUT;
					phase_d   = PH_ABORT;
				end
			end
			MODE_BEGIN: begin
				phase_d   = cfg.pre_clean_enable ? PH_STARTPRE : PH_STARTLOAD;
				step_ms_d = {6'b0, begin_ms};
				start_d   = '0;
				elapsed_d = '0;
				started_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// result word straight from the state registers
	assign res.phase      = phase_q;
	assign res.valve_mask = valve_q;
	assign res.pump_mode  = pump_q;
	assign res.elapsed_ms = started_q ? elapsed_q : '0;
	assign res.done_res   = (phase_q == PH_FINISHED);

endmodule

`default_nettype wire

// ===== rtl/valve_pump_step_sequencer.sv =====
// valve_pump_step_sequencer: top level with input register, config registers, result handshake
// depends on vpss_pkg and vpss_core
`default_nettype none

// Timed sequencer for one liquid-handling step (pre-clean, fill, hold, drain,
// post-clean). Every input word (tick, abort or begin, with the ms clock) gives
// exactly one result word. A word is held in an input register, then the state
// update runs in one pass once the result slot is free, and the state registers,
// which double as the result register, show the result. res_valid rises as the
// state registers take the update; the block takes one word per cycle as long as
// res_stall stays low. A stalled result holds the state, and a second word waits
// in the input register before item_stall rises. Configuration writes are always
// ready and must only be issued while no word is in flight.
module valve_pump_step_sequencer import vpss_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// input words
	input  wire logic                 item_valid,
	output logic                      item_stall,
	input  wire logic [MODE_W-1:0]    mode,
	input  wire logic [STAMP_W-1:0]   now_ms,
	// result words
	output logic                      res_valid,
	input  wire logic                 res_stall,
	output logic [PHASE_W-1:0]        phase,
	output logic [VALVE_W-1:0]        valve_mask,
	output logic [PUMP_W-1:0]         pump_mode,
	output logic [STAMP_W-1:0]        elapsed_ms,
	output logic                      done_res,
	// configuration writes
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data
);

	logic  item_valid_s1;
	item_t item_s1;
	logic  res_valid_q;
	logic  step_en;
	cfg_t  cfg_q;
	res_t  res;

	// the word in the input register moves on when the result slot is free
	assign step_en    = item_valid_s1 && (!res_valid_q || !res_stall);
	assign item_stall = item_valid_s1 && !step_en;
	assign cfg_ready  = 1'b1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1.mode   <= mode;
			item_s1.now_ms <= now_ms;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step_en) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_seconds     <= '0;
			cfg_q.fill_ms          <= '0;
			cfg_q.chem_select      <= '0;
			cfg_q.pre_clean_enable <= 1'b0;
			cfg_q.pre_clean_ms     <= CLEAN_MS_RST;
			cfg_q.post_clean_ms    <= CLEAN_MS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_STEP_SECONDS: cfg_q.step_seconds     <= cfg_data[15:0];
				CFG_FILL_MS:      cfg_q.fill_ms          <= cfg_data[23:0];
				CFG_CHEM_SELECT:  cfg_q.chem_select      <= cfg_data[2:0];
				CFG_PRE_CLEAN_EN: cfg_q.pre_clean_enable <= cfg_data[0];
				CFG_PRE_CLEAN_MS: cfg_q.pre_clean_ms     <= cfg_data[15:0];
				CFG_POST_CLEAN:   cfg_q.post_clean_ms    <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer state and update
	vpss_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.item    (item_s1),
		.cfg     (cfg_q),
		.res     (res)
	);

	// result ports
	assign res_valid  = res_valid_q;
	assign phase      = res.phase;
	assign valve_mask = res.valve_mask;
	assign pump_mode  = res.pump_mode;
	assign elapsed_ms = res.elapsed_ms;
	assign done_res   = res.done_res;

endmodule

`default_nettype wire

// ===== rtl/vpss_checker.sv =====
// vpss_checker: port-level assertions for the step sequencer, bound to the top level
// depends on vpss_pkg and valve_pump_step_sequencer
`default_nettype none

module vpss_checker import vpss_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               res_valid,
	input wire logic               res_stall,
	input wire logic [PHASE_W-1:0] phase,
	input wire logic [VALVE_W-1:0] valve_mask,
	input wire logic [PUMP_W-1:0]  pump_mode,
	input wire logic [STAMP_W-1:0] elapsed_ms,
	input wire logic               done_res
);

	// a stalled result word holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(phase) && $stable(valve_mask)
			&& $stable(pump_mode) && $stable(elapsed_ms) && $stable(done_res))
		else $error("result word changed while stalled");

	// done flag follows the finished phase
	a_done_phase: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (done_res == (phase == PH_FINISHED)))
		else $error("done flag does not match phase");

	// a finished step leaves the pump stopped
	a_done_pump: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && done_res |-> pump_mode == PUMP_STOP)
		else $error("pump running after step finished");

	// the phase timer is not armed before the fill starts
	a_pre_elapsed: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (phase == PH_STARTPRE || phase == PH_PRECLEAN
			|| phase == PH_STARTLOAD) |-> elapsed_ms == '0)
		else $error("elapsed time reported before fill");

endmodule

bind valve_pump_step_sequencer vpss_checker u_vpss_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.phase      (phase),
	.valve_mask (valve_mask),
	.pump_mode  (pump_mode),
	.elapsed_ms (elapsed_ms),
	.done_res   (done_res)
);

`default_nettype wire

// ===== verif/vpss_status_checker.sv =====
// vpss_status_checker: predicts every status word of the valve/pump step sequencer and compares
// the words the block returns; depends on vpss_pkg, sits beside the block in the test top
`timescale 1ns / 1ps

module vpss_status_checker import vpss_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	input  wire logic                 item_stall,
	input  wire logic [MODE_W-1:0]    mode,
	input  wire logic [STAMP_W-1:0]   now_ms,
	input  wire logic                 res_valid,
	input  wire logic                 res_stall,
	input  wire logic [PHASE_W-1:0]   phase,
	input  wire logic [VALVE_W-1:0]   valve_mask,
	input  wire logic [PUMP_W-1:0]    pump_mode,
	input  wire logic [STAMP_W-1:0]   elapsed_ms,
	input  wire logic                 done_res,
	input  wire logic                 cfg_valid,
	input  wire logic                 cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data,
	output int                        fail_count,
	output int                        pending
);

	// extra drain time granted when a fill is aborted
	localparam logic [33:0] ABORT_MARGIN_MS = 34'd1000;

	// shadow copy of the registers and of the sequencer state
	cfg_t               regs;
	phase_t             seq_phase;
	logic [31:0]        stamp;
	logic [31:0]        elapsed;
	logic [31:0]        step_ms;
	logic               timer_on;
	logic [VALVE_W-1:0] valves;
	pump_t              pump;

	res_t expected_status[$];
	int   mismatch_total = 0;
	int   in_flight = 0;

	assign fail_count = mismatch_total;
	assign pending = in_flight;

	function automatic logic water_selected();
		return regs.chem_select >= CHEM_WATER;
	endfunction

	// valve the tank is filled through
	function automatic logic [VALVE_W-1:0] fill_valve();
		if (water_selected()) begin
			return WATER_BIT;
		end
		return 6'd1 << regs.chem_select;
	endfunction

	// valve the tank is emptied through
	function automatic logic [VALVE_W-1:0] empty_valve();
		if (water_selected()) begin
			return WASTE_BIT;
		end
		return fill_valve();
	endfunction

	// timer update, then the phase transitions; sums are compared without wrapping
	function automatic void tick_sequencer(logic [31:0] now);
		logic [63:0] e;
		logic [63:0] post;
		logic [63:0] step;
		logic [63:0] fill;
		if (stamp == 32'd0) begin
			stamp = now;
		end
		elapsed = now - stamp;
		e = 64'(elapsed);
		post = 64'(regs.post_clean_ms);
		step = 64'(step_ms);
		fill = 64'(regs.fill_ms);
		case (seq_phase)
		PH_STARTPRE: begin
			valves |= WASTE_BIT;
			pump = PUMP_OUT;
			seq_phase = PH_PRECLEAN;
		end
		PH_PRECLEAN: begin
			if (e >= 64'(regs.pre_clean_ms)) begin
				valves &= ~WASTE_BIT;
				pump = PUMP_STOP;
				seq_phase = PH_STARTLOAD;
			end
		end
		PH_STARTLOAD: begin
			valves |= fill_valve();
			pump = PUMP_IN;
			elapsed = 32'd0;
			stamp = now;
			timer_on = 1'b1;
			seq_phase = PH_LOAD;
		end
		PH_LOAD: begin
			if (e >= fill) begin
				valves &= ~fill_valve();
				pump = PUMP_STOP;
				seq_phase = PH_EXECUTE;
			end
		end
		PH_EXECUTE: begin
			if (e + fill + post >= step) begin
				valves |= empty_valve();
				pump = PUMP_OUT;
				seq_phase = PH_UNLOAD;
			end
		end
		PH_UNLOAD, PH_ABORT: begin
			if (e + post >= step) begin
				// water leaves its valve alone, it drained through waste
				if (!water_selected()) begin
					valves &= ~fill_valve();
				end
				seq_phase = PH_STARTPOST;
			end
		end
		PH_STARTPOST: begin
			valves |= WASTE_BIT;
			pump = PUMP_OUT;
			seq_phase = PH_POSTCLEAN;
		end
		PH_POSTCLEAN: begin
			if (e >= step) begin
				valves &= ~WASTE_BIT;
				pump = PUMP_STOP;
				seq_phase = PH_FINISHED;
			end
		end
		default: begin
		end
		endcase
	endfunction

	// abort rewrites the remaining time by phase; late phases ignore it
	function automatic void abort_sequencer(logic [31:0] now);
		logic [33:0] stretched;
		case (seq_phase)
		PH_STARTPRE, PH_PRECLEAN, PH_STARTLOAD: begin
			step_ms = 32'd0;
		end
		PH_LOAD: begin
			stretched = 34'(elapsed) + 34'(regs.post_clean_ms) + ABORT_MARGIN_MS;
			step_ms = (stretched > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : stretched[31:0];
		end
		PH_EXECUTE: begin
			step_ms = 32'(regs.fill_ms) + 32'(regs.post_clean_ms);
		end
		default: begin
			return;
		end
		endcase
		elapsed = 32'd0;
		stamp = now;
		valves |= empty_valve();
		pump = PUMP_OUT;
		seq_phase = PH_ABORT;
	endfunction

	// a new step latches its duration; valves and pump stay as they are
	function automatic void begin_step();
		seq_phase = regs.pre_clean_enable ? PH_STARTPRE : PH_STARTLOAD;
		step_ms = 32'(regs.step_seconds) * 32'd1000;
		stamp = 32'd0;
		elapsed = 32'd0;
		timer_on = 1'b0;
	endfunction

	function automatic res_t current_status();
		res_t word;
		word.phase = seq_phase;
		word.valve_mask = valves;
		word.pump_mode = pump;
		word.elapsed_ms = timer_on ? elapsed : 32'd0;
		word.done_res = (seq_phase == PH_FINISHED);
		return word;
	endfunction

	function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
		case (idx)
		CFG_STEP_SECONDS: regs.step_seconds = data[15:0];
		CFG_FILL_MS:      regs.fill_ms = data[23:0];
		CFG_CHEM_SELECT:  regs.chem_select = data[2:0];
		CFG_PRE_CLEAN_EN: regs.pre_clean_enable = data[0];
		CFG_PRE_CLEAN_MS: regs.pre_clean_ms = data[15:0];
		CFG_POST_CLEAN:   regs.post_clean_ms = data[15:0];
		default: begin
		end
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t ns: status mismatch on %s: got %0h, expected %0h", $time, what, got, want);
		mismatch_total++;
	endtask

	// watch the three channels at every rising edge
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			regs.step_seconds = 16'd0;
			regs.fill_ms = 24'd0;
			regs.chem_select = 3'd0;
			regs.pre_clean_enable = 1'b0;
			regs.pre_clean_ms = CLEAN_MS_RST;
			regs.post_clean_ms = CLEAN_MS_RST;
			seq_phase = PH_FINISHED;
			stamp = 32'd0;
			elapsed = 32'd0;
			step_ms = 32'd0;
			timer_on = 1'b0;
			valves = '0;
			pump = PUMP_STOP;
			expected_status.delete();
			in_flight = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				apply_write(cfg_index, cfg_data);
			end
			// accepted input word: predict its status word
			if (item_valid && !item_stall) begin
				case (mode)
				MODE_TICK:  tick_sequencer(now_ms);
				MODE_ABORT: abort_sequencer(now_ms);
				MODE_BEGIN: begin_step();
				default: begin
				end
				endcase
				expected_status.push_back(current_status());
			end
			// accepted result word: compare with the oldest prediction
			if (res_valid && !res_stall) begin
				if (expected_status.size() == 0) begin
					report_mismatch("word with nothing pending", 32'(phase), 32'd0);
				end else begin
					want = expected_status.pop_front();
					if (phase !== want.phase) begin
						report_mismatch("phase", 32'(phase), 32'(want.phase));
					end
					if (valve_mask !== want.valve_mask) begin
						report_mismatch("valve_mask", 32'(valve_mask), 32'(want.valve_mask));
					end
					if (pump_mode !== want.pump_mode) begin
						report_mismatch("pump_mode", 32'(pump_mode), 32'(want.pump_mode));
					end
					if (elapsed_ms !== want.elapsed_ms) begin
						report_mismatch("elapsed_ms", elapsed_ms, want.elapsed_ms);
					end
					if (done_res !== want.done_res) begin
						report_mismatch("done_res", 32'(done_res), 32'(want.done_res));
					end
				end
			end
			in_flight = expected_status.size();
		end
	end

endmodule

// ===== verif/valve_pump_step_sequencer_test.sv =====
// valve_pump_step_sequencer_test: drives step sequences, register settings and back-pressure
// into the sequencer; depends on vpss_pkg, the block and vpss_status_checker
`timescale 1ns / 1ps

module valve_pump_step_sequencer_test;
	import vpss_pkg::*;

	// mode code the block treats as a no-op
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	// register index with no register behind it
	localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd7;
	localparam int WORD_TARGET = 620;
	localparam int LONG_HOLD_CYCLES = 150;
	localparam int HOLD_AT_WORD = 150;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_stall;
	logic [MODE_W-1:0]    mode = MODE_TICK;
	logic [STAMP_W-1:0]   now_ms = '0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	logic [PHASE_W-1:0]   phase;
	logic [VALVE_W-1:0]   valve_mask;
	logic [PUMP_W-1:0]    pump_mode;
	logic [STAMP_W-1:0]   elapsed_ms;
	logic                 done_res;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_STEP_SECONDS;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	int fail_count;
	int pending;

	item_t       stim_words[$];
	int          words_made = 0;
	logic [31:0] wall_ms = '0;
	int          max_inc = 1000;
	bit          sender_calm = 1'b0;

	valve_pump_step_sequencer dut (.*);

	vpss_status_checker status_check (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit
	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// result side: random stalls, calm stretches and one long hold-off
	initial begin
		int gap;
		int taken;
		bit calm;
		taken = 0;
		calm = 1'b0;
		forever begin
			if ($urandom_range(0, 39) == 0) begin
				calm = !calm;
			end
			gap = calm ? 0 : $urandom_range(0, 17);
			if (taken == HOLD_AT_WORD) begin
				gap = LONG_HOLD_CYCLES;
			end
			if (gap > 0) begin
				res_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			res_stall <= 1'b0;
			do @(posedge clk); while (!res_valid);
			taken++;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// random bits above the register width, which the block must drop
	function automatic logic [CFG_DAT_W-1:0] with_junk(logic [CFG_DAT_W-1:0] value, int width);
		logic [CFG_DAT_W-1:0] junk;
		junk = CFG_DAT_W'($urandom) << width;
		return junk | value;
	endfunction

	function automatic void push_word(logic [MODE_W-1:0] m, logic [STAMP_W-1:0] t);
		item_t w;
		w.mode = m;
		w.now_ms = t;
		stim_words.push_back(w);
		words_made++;
	endfunction

	// move the millisecond clock on; now and then a zero stamp or a jump
	function automatic logic [31:0] advance();
		int r;
		r = $urandom_range(0, 99);
		if (r == 0) begin
			wall_ms = 32'd0;
		end else if (r == 1) begin
			wall_ms = $urandom;
		end else begin
			wall_ms = wall_ms + 32'($urandom_range(0, max_inc));
		end
		return wall_ms;
	endfunction

	// one step: begin, then mostly ticks, maybe one planned abort, a little noise
	function automatic void queue_step(int ticks);
		int i;
		int abort_at;
		int r;
		abort_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, ticks - 1) : -1;
		push_word(MODE_BEGIN, advance());
		for (i = 0; i < ticks; i++) begin
			r = $urandom_range(0, 99);
			if (i == abort_at || r < 2) begin
				push_word(MODE_ABORT, advance());
			end else if (r < 4) begin
				push_word(MODE_UNUSED, $urandom);
			end else if (r < 5) begin
				push_word(MODE_BEGIN, advance());
			end else begin
				push_word(MODE_TICK, advance());
			end
		end
	endfunction

	// sender: random gaps, calm stretches; payload held while stalled
	task automatic send_words();
		int gap;
		while (stim_words.size() > 0) begin
			if ($urandom_range(0, 39) == 0) begin
				sender_calm = !sender_calm;
			end
			gap = sender_calm ? 0 : $urandom_range(0, 17);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			item_valid <= 1'b1;
			mode <= stim_words[0].mode;
			now_ms <= stim_words[0].now_ms;
			void'(stim_words.pop_front());
			do @(posedge clk); while (item_stall);
		end
		item_valid <= 1'b0;
	endtask

	// wait for every status word, then let the block go quiet
	task automatic settle();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register set for one phase: all maximum, all zero, or small random times
	task automatic load_settings(int p);
		if (p == 0) begin
			write_reg(CFG_STEP_SECONDS, with_junk(24'hFFFF, 16));
			write_reg(CFG_FILL_MS, 24'hFF_FFFF);
			write_reg(CFG_CHEM_SELECT, with_junk(24'd7, 3));
			write_reg(CFG_PRE_CLEAN_EN, with_junk(24'd1, 1));
			write_reg(CFG_PRE_CLEAN_MS, with_junk(24'hFFFF, 16));
			write_reg(CFG_POST_CLEAN, with_junk(24'hFFFF, 16));
			max_inc = 32'h0400_0000;
		end else if (p == 1) begin
			write_reg(CFG_STEP_SECONDS, 24'd0);
			write_reg(CFG_FILL_MS, 24'd0);
			write_reg(CFG_CHEM_SELECT, 24'd0);
			write_reg(CFG_PRE_CLEAN_EN, 24'd0);
			write_reg(CFG_PRE_CLEAN_MS, 24'd0);
			write_reg(CFG_POST_CLEAN, 24'd0);
			max_inc = 50;
		end else begin
			write_reg(CFG_STEP_SECONDS, with_junk(24'($urandom_range(0, 4)), 16));
			write_reg(CFG_FILL_MS, 24'($urandom_range(0, 3000)));
			write_reg(CFG_CHEM_SELECT, with_junk(24'($urandom_range(0, 7)), 3));
			write_reg(CFG_PRE_CLEAN_EN, with_junk(24'($urandom_range(0, 1)), 1));
			write_reg(CFG_PRE_CLEAN_MS, with_junk(24'($urandom_range(0, 2500)), 16));
			write_reg(CFG_POST_CLEAN, with_junk(24'($urandom_range(0, 2500)), 16));
			max_inc = $urandom_range(200, 1200);
		end
		// sometimes start just below the clock wrap
		if ($urandom_range(0, 3) == 0) begin
			wall_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 20000));
		end else begin
			wall_ms = $urandom;
		end
	endtask

	initial begin
		int p;
		int n;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed settings: water, pre-clean on, short times
		write_reg(CFG_STEP_SECONDS, 24'd2);
		write_reg(CFG_FILL_MS, 24'd1500);
		write_reg(CFG_CHEM_SELECT, 24'd4);
		write_reg(CFG_PRE_CLEAN_EN, 24'd1);
		write_reg(CFG_PRE_CLEAN_MS, 24'd1000);
		write_reg(CFG_POST_CLEAN, 24'd500);
		write_reg(CFG_NONE, 24'hFF_FFFF);

		// idle block: tick, ignored abort, unused mode
		push_word(MODE_TICK, 32'd123);
		push_word(MODE_ABORT, 32'd5);
		push_word(MODE_UNUSED, 32'hFFFF_FFFF);
		// full step with a zero stamp, a wrap and an abort during fill
		push_word(MODE_BEGIN, 32'd0);
		push_word(MODE_TICK, 32'd0);
		push_word(MODE_TICK, 32'hFFFF_FF00);
		push_word(MODE_TICK, 32'h0000_0100);
		push_word(MODE_TICK, 32'h0000_03F0);
		push_word(MODE_TICK, 32'h0000_0400);
		push_word(MODE_TICK, 32'h0000_0800);
		push_word(MODE_ABORT, 32'h0000_0900);
		push_word(MODE_TICK, 32'h0000_0900 + 32'd2024);
		push_word(MODE_TICK, 32'h0000_0900 + 32'd2025);
		push_word(MODE_TICK, 32'h0000_0900 + 32'd2035);
		push_word(MODE_TICK, 32'h0000_0900 + 32'd2524);
		// abort before the pre-clean drain starts
		push_word(MODE_BEGIN, 32'd6);
		push_word(MODE_ABORT, 32'd7);
		push_word(MODE_TICK, 32'd7);
		push_word(MODE_TICK, 32'd8);
		push_word(MODE_TICK, 32'd9);
		// half-range elapsed time, then abort right after fill starts
		push_word(MODE_BEGIN, 32'd10);
		push_word(MODE_TICK, 32'hFFFF_FFFF);
		push_word(MODE_TICK, 32'h7FFF_FFFF);
		push_word(MODE_TICK, 32'h8000_0000);
		push_word(MODE_ABORT, 32'h8000_0010);
		send_words();
		settle();

		// random phases, each with fresh settings
		p = 0;
		while (words_made < WORD_TARGET) begin
			load_settings(p);
			n = $urandom_range(2, 3);
			repeat (n) queue_step($urandom_range(12, 36));
			send_words();
			settle();
			p++;
		end

		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
